// ===== design/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

  // Line buffer geometry.
  localparam int BUF_DEPTH = 32;
  localparam int CNT_W     = $clog2(BUF_DEPTH);
  localparam int CAP_W     = 6;
  localparam int LEN_W     = 5;
  localparam int BYTE_W    = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Character codes the editor reacts to.
  localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
  localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_UC_C  = 8'h43;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    END_ENTER  = 2'd0,
    END_FULL   = 2'd1,
    END_CANCEL = 2'd2,
    END_EOF    = 2'd3
  } status_e;

  // Which echo sequence a word produces.
  typedef enum logic [1:0] {
    ACT_ENTER  = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_PRINT  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_ECHO  = 3'd1,
    S_RADDR = 3'd2,
    S_RDATA = 3'd3,
    S_DONE  = 3'd4
  } state_e;

  // Decoded effect of one received character.
  typedef struct packed {
    logic [1:0]       echo_n;
    act_e             act;
    logic             fin;
    status_e          status;
    logic             store;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] len;
  } decode_t;

  // Byte number idx of the echo sequence for an action.
  function automatic logic [BYTE_W-1:0] echo_byte(act_e act, logic [BYTE_W-1:0] ch,
                                                  logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (act)
      ACT_ENTER:  b = CH_LF;
      ACT_ERASE:  b = (idx == 2'd1) ? CH_SPACE : CH_BS;
      ACT_CANCEL: b = (idx == 2'd0) ? CH_CARET : ((idx == 2'd1) ? CH_UC_C : CH_LF);
      ACT_PRINT:  b = ch;
      default:    b = ch;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/cle_ram.sv =====
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/cle_decode.sv =====
`default_nettype none

module cle_decode (
  input  wire logic [cle_pkg::BYTE_W-1:0] char_i,
  input  wire logic [cle_pkg::CNT_W-1:0]  count_i,
  input  wire logic [cle_pkg::CAP_W-1:0]  cap_i,
  output cle_pkg::decode_t                dec_o
);

  logic [cle_pkg::CNT_W-1:0] max_len;
  logic [cle_pkg::CNT_W-1:0] cnt_new;
  logic                      has_room;

  // Clamp the capacity into its legal range and derive the longest line.
  always_comb begin
    if (cap_i < cle_pkg::CAP_W'(2)) begin
      max_len = cle_pkg::CNT_W'(1);
    end else if (cap_i > cle_pkg::CAP_W'(cle_pkg::BUF_DEPTH)) begin
      max_len = cle_pkg::CNT_W'(cle_pkg::BUF_DEPTH - 1);
    end else begin
      max_len = cle_pkg::CNT_W'(cap_i - cle_pkg::CAP_W'(1));
    end
  end

  assign has_room = count_i < cle_pkg::CNT_W'(cle_pkg::BUF_DEPTH - 1);
  assign cnt_new  = has_room ? count_i + cle_pkg::CNT_W'(1) : count_i;

  // Classify the character and work out what it does to the line.
  always_comb begin
    dec_o            = '0;
    dec_o.act        = cle_pkg::ACT_PRINT;
    dec_o.status     = cle_pkg::END_ENTER;
    dec_o.count_next = count_i;
    unique case (char_i) inside
      cle_pkg::CH_LF, cle_pkg::CH_CR: begin
        dec_o.echo_n     = 2'd1;
        dec_o.act        = cle_pkg::ACT_ENTER;
        dec_o.fin        = 1'b1;
        dec_o.status     = cle_pkg::END_ENTER;
        dec_o.len        = count_i;
        dec_o.count_next = '0;
      end
      cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
        if (count_i != '0) begin
          dec_o.echo_n     = 2'd3;
          dec_o.act        = cle_pkg::ACT_ERASE;
          dec_o.count_next = count_i - cle_pkg::CNT_W'(1);
        end
      end
      cle_pkg::CH_ETX: begin
        dec_o.echo_n     = 2'd3;
        dec_o.act        = cle_pkg::ACT_CANCEL;
        dec_o.fin        = 1'b1;
        dec_o.status     = cle_pkg::END_CANCEL;
        dec_o.count_next = '0;
      end
      cle_pkg::CH_EOT: begin
        // End of file only counts on an empty line.
        if (count_i == '0) begin
          dec_o.fin    = 1'b1;
          dec_o.status = cle_pkg::END_EOF;
        end
      end
      [cle_pkg::CH_SPACE:cle_pkg::CH_TILDE]: begin
        dec_o.echo_n     = 2'd1;
        dec_o.act        = cle_pkg::ACT_PRINT;
        dec_o.store      = has_room;
        dec_o.fin        = cnt_new >= max_len;
        dec_o.status     = cle_pkg::END_FULL;
        dec_o.len        = cnt_new;
        dec_o.count_next = (cnt_new >= max_len) ? '0 : cnt_new;
      end
      default: begin
        // Other control bytes and high bytes are dropped silently.
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/console_line_editor_unit.sv =====
`default_nettype none

// Channel  Handshake                       Payload
// cfg      cfg_we_i (no wait)              cfg_data_i: line capacity
// in       in_valid_i / in_ready_o         in_char_i: received byte
// out      out_valid_o / out_ready_i       out_kind_o, out_byte_o, line_length_o,
//                                          end_status_o, last_o
//
// A word is taken in S_IDLE; the sequencer then passes through S_ECHO for each echo word,
// then for each stored byte of a finished line through S_RADDR (line buffer read) and
// S_RDATA (the output register), and ends a finished line in S_DONE for the done word.
// Words that cause nothing leave the sequencer in S_IDLE.
// Reset clears the line count and sets the capacity to 32; buffer contents stay undefined.
// A stalled output holds the sequencer; a new word is taken as soon as the sequencer is
// idle, even while the last result still waits in the output register.

module console_line_editor_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cle_pkg::CAP_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [cle_pkg::BYTE_W-1:0]  in_char_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [1:0]                  out_kind_o,
  output logic      [cle_pkg::BYTE_W-1:0]  out_byte_o,
  output logic      [cle_pkg::LEN_W-1:0]   line_length_o,
  output logic      [1:0]                  end_status_o,
  output logic                             last_o
);

  cle_pkg::state_e           state_q, state_d;
  logic [cle_pkg::CAP_W-1:0] cap_q;
  logic [cle_pkg::CNT_W-1:0] count_q;
  cle_pkg::act_e             act_q;
  logic [cle_pkg::BYTE_W-1:0] char_q;
  logic [1:0]                echo_n_q;
  logic [1:0]                idx_q;
  logic                      fin_q;
  cle_pkg::status_e          status_q;
  logic [cle_pkg::CNT_W-1:0] len_q;
  logic [cle_pkg::CNT_W-1:0] rd_q;

  logic                       out_valid_q;
  cle_pkg::kind_e             out_kind_q;
  logic [cle_pkg::BYTE_W-1:0] out_byte_q;
  logic [cle_pkg::LEN_W-1:0]  out_len_q;
  cle_pkg::status_e           out_status_q;
  logic                       out_last_q;

  cle_pkg::decode_t           dec;
  logic                       in_fire;
  logic                       load;
  logic                       last_echo;
  logic                       last_read;
  logic [cle_pkg::BYTE_W-1:0] rdata;

  logic                       out_set;
  cle_pkg::kind_e             set_kind;
  logic [cle_pkg::BYTE_W-1:0] set_byte;
  logic [cle_pkg::LEN_W-1:0]  set_len;
  cle_pkg::status_e           set_status;
  logic                       set_last;

  assign in_ready_o = (state_q == cle_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = !out_valid_q || out_ready_i;
  assign last_echo  = (idx_q == echo_n_q - 2'd1);
  assign last_read  = (rd_q == len_q - cle_pkg::CNT_W'(1));

  cle_decode u_decode (
    .char_i  (in_char_i),
    .count_i (count_q),
    .cap_i   (cap_q),
    .dec_o   (dec)
  );

  // Line buffer: written when a printable byte is taken, read back at line end.
  cle_ram #(
    .WIDTH (cle_pkg::BYTE_W),
    .DEPTH (cle_pkg::BUF_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && dec.store),
    .waddr_i (count_q),
    .wdata_i (in_char_i),
    .re_i    (state_q == cle_pkg::S_RADDR),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cle_pkg::S_IDLE: begin
        if (in_fire) begin
          if (dec.echo_n != 2'd0) begin
            state_d = cle_pkg::S_ECHO;
          end else if (dec.fin) begin
            state_d = cle_pkg::S_DONE;
          end
        end
      end
      cle_pkg::S_ECHO: begin
        if (load && last_echo) begin
          if (!fin_q) begin
            state_d = cle_pkg::S_IDLE;
          end else if (len_q != '0) begin
            state_d = cle_pkg::S_RADDR;
          end else begin
            state_d = cle_pkg::S_DONE;
          end
        end
      end
      cle_pkg::S_RADDR: state_d = cle_pkg::S_RDATA;
      cle_pkg::S_RDATA: begin
        if (load) begin
          state_d = last_read ? cle_pkg::S_DONE : cle_pkg::S_RADDR;
        end
      end
      cle_pkg::S_DONE: begin
        if (load) begin
          state_d = cle_pkg::S_IDLE;
        end
      end
      default: state_d = cle_pkg::S_IDLE;
    endcase
  end

  // Result word for the output register.
  always_comb begin
    out_set    = 1'b0;
    set_kind   = cle_pkg::KIND_ECHO;
    set_byte   = '0;
    set_len    = '0;
    set_status = cle_pkg::END_ENTER;
    set_last   = 1'b0;
    unique case (state_q)
      cle_pkg::S_ECHO: begin
        out_set  = load;
        set_byte = cle_pkg::echo_byte(act_q, char_q, idx_q);
        set_last = last_echo && !fin_q;
      end
      cle_pkg::S_RDATA: begin
        out_set  = load;
        set_kind = cle_pkg::KIND_LINE;
        set_byte = rdata;
      end
      cle_pkg::S_DONE: begin
        out_set    = load;
        set_kind   = cle_pkg::KIND_DONE;
        set_len    = cle_pkg::LEN_W'(len_q);
        set_status = status_q;
        set_last   = 1'b1;
      end
      default: begin
        out_set = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cle_pkg::S_IDLE;
      cap_q       <= cle_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (in_fire) begin
        count_q <= dec.count_next;
      end
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-word context and sequence counters.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= dec.act;
      char_q   <= in_char_i;
      echo_n_q <= dec.echo_n;
      fin_q    <= dec.fin;
      status_q <= dec.status;
      len_q    <= dec.len;
      idx_q    <= '0;
      rd_q     <= '0;
    end else begin
      if (state_q == cle_pkg::S_ECHO && load) begin
        idx_q <= idx_q + 2'd1;
      end
      if (state_q == cle_pkg::S_RDATA && load) begin
        rd_q <= rd_q + cle_pkg::CNT_W'(1);
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_set) begin
      out_kind_q   <= set_kind;
      out_byte_q   <= set_byte;
      out_len_q    <= set_len;
      out_status_q <= set_status;
      out_last_q   <= set_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign line_length_o = out_len_q;
  assign end_status_o  = out_status_q;
  assign last_o        = out_last_q;

  // The readout never goes past the end of the finished line.
  a_read_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cle_pkg::S_RDATA |-> rd_q < len_q)
    else $error("line readout ran past the line length");

  // A word that ends the line leaves an empty line behind.
  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && dec.fin |=> count_q == '0)
    else $error("line count not cleared at line end");

  // Buffer data is only presented after a read was issued.
  a_read_before_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cle_pkg::S_RDATA |->
      $past(state_q) == cle_pkg::S_RADDR || $past(state_q) == cle_pkg::S_RDATA)
    else $error("line byte presented without a buffer read");

endmodule

`default_nettype wire
